### rtl/core/fac_pkg.sv
package fac_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLED,
        REG_THRESHOLD,
        REG_INV_RATIO,
        REG_ATTACK,
        REG_RELEASE,
        REG_WET_MIX,
        REG_MAKEUP,
        REG_USE_SIDECHAIN
    } cfg_reg_t;

    typedef struct packed {
        logic               enabled;
        logic signed [15:0] threshold_level;
        logic [16:0]        inverse_ratio;
        logic [15:0]        attack_coefficient;
        logic [15:0]        release_coefficient;
        logic [16:0]        wet_mix;
        logic [15:0]        makeup_gain;
        logic               use_sidechain;
    } cfg_t;

    // dB per octave and octave per dB scale factors
    localparam logic [32:0] DB_PER_OCT = 33'd394566;
    localparam logic [32:0] OCT_PER_DB = 33'd174165;

    localparam logic signed [17:0] ZERO_LEVEL = -18'sd25600;
    localparam logic signed [17:0] MAIN_FLOOR = -18'sd24576;
    localparam logic signed [17:0] DBU_OFFSET = 18'sd4608;

    localparam logic [16:0] UNITY_Q16 = 17'd65536;
    localparam logic [63:0] WET_MAX   = (64'd1 << 47) - 64'd1;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = v_in;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bit_v > v) begin
                bit_v = bit_v >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bit_v != 64'd0) begin
                if (v >= res + bit_v) begin
                    v   = v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-(k+1)) in Q30, built by repeated truncating square roots
    function automatic logic [16*31-1:0] build_roots();
        logic [16*31-1:0] tab;
        logic [63:0]      root;
        tab  = '0;
        root = 64'd1 << 31;
        for (int i = 0; i < 16; i++) begin
            root = isqrt64(root << 30);
            tab[i*31 +: 31] = root[30:0];
        end
        return tab;
    endfunction

    localparam logic [16*31-1:0] ROOTS = build_roots();

    function automatic logic signed [15:0] report_gain(input logic signed [23:0] sg);
        logic signed [24:0] s;
        logic signed [16:0] g;
        s = 25'(sg) + 25'sd128;
        g = s[24:8];
        if (g > 17'sd32767) begin
            return 16'sh7fff;
        end
        return g[15:0];
    endfunction

endpackage

### rtl/core/fac_mul.sv
module fac_mul
    import fac_pkg::*;
(
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] product
);

    assign product = 66'(op_a) * 66'(op_b);

endmodule

### rtl/core/fac_core.sv
module fac_core
    import fac_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] main_in,
    input  logic signed [SAMPLE_BITS-1:0] side_in,
    input  logic                          out_free,
    output logic                          busy,
    output logic                          done,
    output logic [SAMPLE_BITS-1:0]        result,
    output logic signed [23:0]            smoothed
);

    localparam int PW = $clog2(SAMPLE_BITS);
    localparam int DW = PW + 16;

    typedef enum logic [3:0] {
        IDLE, NORM, SQR, LOG, GAIN, SM1, SM2, LIN,
        POW, WET, BL1, BL2, BL3, MK1, MK2, FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic                    src_reg, src_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]  xm_reg, xm_next;
    logic [SAMPLE_BITS-1:0]  sm_reg, sm_next;
    logic                    xneg_reg, xneg_next;
    logic [31:0]             y_reg, y_next;
    logic [PW-1:0]           p_reg, p_next;
    logic [15:0]             frac_reg, frac_next;
    logic signed [17:0]      main_lv_reg, main_lv_next;
    logic signed [17:0]      sc_lv_reg, sc_lv_next;
    logic signed [23:0]      g16_reg, g16_next;
    logic [15:0]             coef_reg, coef_next;
    logic signed [65:0]      acc_reg, acc_next;
    logic signed [23:0]      sg_reg, sg_next;
    logic [15:0]             lf_reg, lf_next;
    logic signed [5:0]       n_reg, n_next;
    logic [30:0]             r_reg, r_next;
    logic [46:0]             wet_reg, wet_next;
    logic [47:0]             b_reg, b_next;
    logic [SAMPLE_BITS-1:0]  res_reg, res_next;

    logic signed [32:0] mult_a, mult_b;
    logic signed [65:0] prod;

    fac_mul u_mul (
        .op_a    (mult_a),
        .op_b    (mult_b),
        .product (prod)
    );

    logic [SAMPLE_BITS-1:0] cur_mag;
    logic [PW-1:0]          msb;
    logic [63:0]            y_norm;
    logic [DW-1:0]          dval;
    logic signed [17:0]     lvl_raw;
    logic signed [17:0]     lvl_main_adj;
    logic signed [17:0]     det_lv;
    logic signed [17:0]     thr;
    logic signed [17:0]     dlt;
    logic [16:0]            dlt_mag;
    logic [16:0]            ir_c;
    logic [16:0]            wc;
    logic signed [65:0]     rnd;
    logic signed [17:0]     gc;
    logic [15:0]            coef_sel;
    logic [6:0]             shamt;
    logic [63:0]            wround;
    logic [63:0]            wshift;
    logic signed [65:0]     tot;
    logic [SAMPLE_BITS:0]   lim;
    logic [SAMPLE_BITS:0]   osat;
    logic [32:0]            sq;

    assign cur_mag = src_reg ? sm_reg : xm_reg;

    always_comb
    begin
        msb = '0;
        for (int k = 0; k < SAMPLE_BITS; k++) begin
            if (cur_mag[k]) begin
                msb = PW'(k);
            end
        end
    end

    assign y_norm = (64'(cur_mag) << 30) >> msb;
    assign dval   = DW'((SAMPLE_BITS - 1) << 16) - {p_reg, frac_reg};
    assign thr    = 18'(cfg.threshold_level);
    assign ir_c   = (cfg.inverse_ratio > UNITY_Q16) ? UNITY_Q16 : cfg.inverse_ratio;
    assign wc     = (cfg.wet_mix > UNITY_Q16) ? UNITY_Q16 : cfg.wet_mix;
    assign det_lv = cfg.use_sidechain ? sc_lv_reg : main_lv_reg;
    assign dlt    = main_lv_reg - thr;
    assign dlt_mag = dlt[17] ? 17'(-dlt) : dlt[16:0];
    assign lvl_main_adj = ((lvl_raw < MAIN_FLOOR) ? MAIN_FLOOR : lvl_raw) + DBU_OFFSET;
    assign coef_sel = (g16_reg < sg_reg) ? cfg.attack_coefficient : cfg.release_coefficient;
    assign shamt  = 7'(8'sd30 - 8'(n_reg));
    assign lim    = (SAMPLE_BITS+1)'(1) << (SAMPLE_BITS - 1);

    always_comb
    begin
        state_next   = state_reg;
        src_next     = src_reg;
        cnt_next     = cnt_reg;
        xm_next      = xm_reg;
        sm_next      = sm_reg;
        xneg_next    = xneg_reg;
        y_next       = y_reg;
        p_next       = p_reg;
        frac_next    = frac_reg;
        main_lv_next = main_lv_reg;
        sc_lv_next   = sc_lv_reg;
        g16_next     = g16_reg;
        coef_next    = coef_reg;
        acc_next     = acc_reg;
        sg_next      = sg_reg;
        lf_next      = lf_reg;
        n_next       = n_reg;
        r_next       = r_reg;
        wet_next     = wet_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        mult_a       = '0;
        mult_b       = '0;
        lvl_raw      = ZERO_LEVEL;
        rnd          = '0;
        gc           = '0;
        wround       = '0;
        wshift       = '0;
        tot          = '0;
        osat         = '0;
        sq           = '0;
        done         = 1'b0;

        unique case (state_reg)
            IDLE:
            begin
                if (start) begin
                    xneg_next = main_in[SAMPLE_BITS-1];
                    xm_next   = main_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-main_in) : main_in;
                    sm_next   = side_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-side_in) : side_in;
                    src_next  = 1'b0;
                    if (cfg.enabled) begin
                        state_next = NORM;
                    end
                    else begin
                        res_next   = main_in;
                        state_next = FIN;
                    end
                end
            end
            NORM:
            begin
                if (cur_mag == '0) begin
                    lvl_raw = ZERO_LEVEL;
                    if (src_reg) begin
                        sc_lv_next = lvl_raw + DBU_OFFSET;
                        state_next = GAIN;
                    end
                    else begin
                        main_lv_next = lvl_main_adj;
                        src_next     = 1'b1;
                    end
                end
                else begin
                    p_next     = msb;
                    y_next     = y_norm[31:0];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = SQR;
                end
            end
            SQR:
            begin
                // mantissa squared in Q1.30, a carry past 2.0 gives one fraction bit
                mult_a = 33'(y_reg);
                mult_b = 33'(y_reg);
                sq     = prod[62:30];
                if (sq[31]) begin
                    frac_next = {frac_reg[14:0], 1'b1};
                    y_next    = sq[32:1];
                end
                else begin
                    frac_next = {frac_reg[14:0], 1'b0};
                    y_next    = sq[31:0];
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = LOG;
                end
            end
            LOG:
            begin
                mult_a  = 33'(dval);
                mult_b  = DB_PER_OCT;
                rnd     = (prod + 66'sd8388608) >>> 24;
                lvl_raw = -rnd[17:0];
                if (src_reg) begin
                    sc_lv_next = lvl_raw + DBU_OFFSET;
                    state_next = GAIN;
                end
                else begin
                    main_lv_next = lvl_main_adj;
                    src_next     = 1'b1;
                    state_next   = NORM;
                end
            end
            GAIN:
            begin
                mult_a = 33'(dlt_mag);
                mult_b = 33'(UNITY_Q16 - ir_c);
                rnd    = (prod + 66'sd32768) >>> 16;
                if (det_lv > thr) begin
                    gc = (dlt > 18'sd0) ? -rnd[17:0] : rnd[17:0];
                    if (gc < -18'sd32768) begin
                        gc = -18'sd32768;
                    end
                    else if (gc > 18'sd32767) begin
                        gc = 18'sd32767;
                    end
                end
                g16_next   = {gc[15:0], 8'd0};
                state_next = SM1;
            end
            SM1:
            begin
                mult_a     = 33'(g16_reg);
                mult_b     = 33'(UNITY_Q16 - 17'(coef_sel));
                coef_next  = coef_sel;
                acc_next   = prod;
                state_next = SM2;
            end
            SM2:
            begin
                mult_a     = 33'(sg_reg);
                mult_b     = 33'(coef_reg);
                rnd        = (acc_reg + prod + 66'sd32768) >>> 16;
                sg_next    = rnd[23:0];
                state_next = LIN;
            end
            LIN:
            begin
                mult_a     = 33'(sg_reg);
                mult_b     = OCT_PER_DB;
                rnd        = (prod + 66'sd524288) >>> 20;
                lf_next    = rnd[15:0];
                n_next     = rnd[21:16];
                r_next     = 31'd1 << 30;
                cnt_next   = '0;
                state_next = POW;
            end
            POW:
            begin
                mult_a = 33'(r_reg);
                mult_b = 33'(ROOTS[32'(cnt_reg)*31 +: 31]);
                if (lf_reg[~cnt_reg]) begin
                    rnd    = (prod + 66'sd536870912) >>> 30;
                    r_next = rnd[30:0];
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = WET;
                end
            end
            WET:
            begin
                mult_a = 33'(xm_reg);
                mult_b = 33'(r_reg);
                wround = prod[63:0] + (64'd1 << (shamt - 7'd1));
                wshift = wround >> shamt;
                wet_next   = (wshift > WET_MAX) ? WET_MAX[46:0] : wshift[46:0];
                state_next = BL1;
            end
            BL1:
            begin
                mult_a     = 33'(xm_reg);
                mult_b     = 33'(UNITY_Q16 - wc);
                acc_next   = prod;
                state_next = BL2;
            end
            BL2:
            begin
                mult_a     = 33'(wet_reg[23:0]);
                mult_b     = 33'(wc);
                acc_next   = acc_reg + prod;
                state_next = BL3;
            end
            BL3:
            begin
                mult_a     = 33'(wet_reg[46:24]);
                mult_b     = 33'(wc);
                tot        = acc_reg + (prod <<< 24) + 66'sd32768;
                b_next     = tot[63:16];
                state_next = MK1;
            end
            MK1:
            begin
                mult_a     = 33'(b_reg[23:0]);
                mult_b     = 33'(cfg.makeup_gain);
                acc_next   = prod;
                state_next = MK2;
            end
            MK2:
            begin
                mult_a = 33'(b_reg[47:24]);
                mult_b = 33'(cfg.makeup_gain);
                tot    = (acc_reg + (prod <<< 24) + 66'sd2048) >>> 12;
                // positive side limits one below full scale
                if (tot > 66'(lim - (SAMPLE_BITS+1)'(!xneg_reg))) begin
                    osat = lim - (SAMPLE_BITS+1)'(!xneg_reg);
                end
                else begin
                    osat = tot[SAMPLE_BITS:0];
                end
                res_next   = xneg_reg ? SAMPLE_BITS'(-osat) : osat[SAMPLE_BITS-1:0];
                state_next = FIN;
            end
            FIN:
            begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= IDLE;
            sg_reg    <= '0;
        end
        else begin
            state_reg <= state_next;
            sg_reg    <= sg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        cnt_reg     <= cnt_next;
        xm_reg      <= xm_next;
        sm_reg      <= sm_next;
        xneg_reg    <= xneg_next;
        y_reg       <= y_next;
        p_reg       <= p_next;
        frac_reg    <= frac_next;
        main_lv_reg <= main_lv_next;
        sc_lv_reg   <= sc_lv_next;
        g16_reg     <= g16_next;
        coef_reg    <= coef_next;
        acc_reg     <= acc_next;
        lf_reg      <= lf_next;
        n_reg       <= n_next;
        r_reg       <= r_next;
        wet_reg     <= wet_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
    end

    assign busy     = (state_reg != IDLE);
    assign result   = res_reg;
    assign smoothed = sg_reg;

endmodule

### rtl/core/feedforward_audio_compressor_top.sv
// Feed-forward compressor, one main and one sidechain sample per request.
// Input channel: in_valid / in_stall with main_sample and sidechain_sample.
// Output channel: out_valid / out_stall with output_sample and gain_change.
// Configuration: cfg_write with cfg_index and cfg_data, taken on any edge;
// write only while no request is in flight.
// One request is worked at a time by a single shared 33x33 multiplier under
// a sequencer: two log conversions (normalise, squarings, log scale; only
// the normalise step when the magnitude is zero), gain and smoothing, the
// 16-step power of two, then the wet product, blend and makeup; in_stall
// stays high while a request is worked.
// Results sit in an output register; a new request can be taken while the
// previous result waits, and the sequencer holds its last step until the
// output register is free, so a stalled receiver stalls the input side.
// Reset clears the smoothed gain to 0 dB and loads register defaults
// (disabled, 1:1 ratio, unity makeup).
module feedforward_audio_compressor_top
    import fac_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] main_sample,
    input  logic signed [SAMPLE_BITS-1:0] sidechain_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] output_sample,
    output logic signed [15:0]            gain_change,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    cfg_t                   cfg_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] output_sample_reg;
    logic signed [15:0]     gain_change_reg;
    logic                   busy;
    logic                   done;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] result;
    logic signed [23:0]     smoothed;
    cfg_reg_t               cfg_sel;

    assign cfg_sel  = cfg_reg_t'(cfg_index);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.enabled             <= 1'b0;
            cfg_reg.threshold_level     <= '0;
            cfg_reg.inverse_ratio       <= UNITY_Q16;
            cfg_reg.attack_coefficient  <= '0;
            cfg_reg.release_coefficient <= '0;
            cfg_reg.wet_mix             <= '0;
            cfg_reg.makeup_gain         <= 16'd4096;
            cfg_reg.use_sidechain       <= 1'b0;
        end
        else if (cfg_write) begin
            unique case (cfg_sel)
                REG_ENABLED:       cfg_reg.enabled             <= cfg_data[0];
                REG_THRESHOLD:     cfg_reg.threshold_level     <= cfg_data[15:0];
                REG_INV_RATIO:     cfg_reg.inverse_ratio       <= cfg_data;
                REG_ATTACK:        cfg_reg.attack_coefficient  <= cfg_data[15:0];
                REG_RELEASE:       cfg_reg.release_coefficient <= cfg_data[15:0];
                REG_WET_MIX:       cfg_reg.wet_mix             <= cfg_data;
                REG_MAKEUP:        cfg_reg.makeup_gain         <= cfg_data[15:0];
                REG_USE_SIDECHAIN: cfg_reg.use_sidechain       <= cfg_data[0];
                default:           cfg_reg.enabled             <= cfg_reg.enabled;
            endcase
        end
    end

    fac_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (in_valid && !busy),
        .main_in  (main_sample),
        .side_in  (sidechain_sample),
        .out_free (out_free),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .smoothed (smoothed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (done) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done) begin
            output_sample_reg <= result;
            gain_change_reg   <= report_gain(smoothed);
        end
    end

    assign in_stall      = busy;
    assign out_valid     = out_valid_reg;
    assign output_sample = output_sample_reg;
    assign gain_change   = gain_change_reg;

    // a result is only handed over when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(out_valid_reg && out_stall))
        else $error("result finished over a held output");

    // a taken request keeps the input side stalled next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while sequencer idle afterwards");

    // output drains when taken and nothing new finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !done) |=> !out_valid_reg)
        else $error("output request repeated");

    // sequencer only finishes while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without a request in flight");

endmodule

### sim/fac_scoreboard.sv
module fac_scoreboard
    import fac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [23:0] main_sample,
    input  logic signed [23:0] sidechain_sample,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [23:0] output_sample,
    input  logic signed [15:0] gain_change,
    input  logic               cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                 errors,
    output int                 pending,
    output int                 requests,
    output int                 compressed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [23:0] sample;
        logic signed [15:0] gain;
    } fac_result_t;

    fac_result_t result_q[$];
    cfg_t        shadow_cfg;
    int          held_gain_q16;
    logic [63:0] root_q30[16];

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    initial begin
        logic [63:0] root;
        root = 64'd1 << 31;
        for (int i = 0; i < 16; i++) begin
            root = floor_sqrt(root << 30);
            root_q30[i] = root;
        end
    end

    // level in Q7.8 dBFS from a magnitude
    function automatic int level_dbfs(input logic [63:0] mag);
        int          msb;
        logic [63:0] y;
        logic [63:0] d;
        logic [15:0] frac;
        if (mag == 0) begin
            return int'(ZERO_LEVEL);
        end
        msb = 0;
        for (int k = 0; k < 25; k++) begin
            if (mag[k]) begin
                msb = k;
            end
        end
        y = mag << (30 - msb);
        frac = '0;
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            frac = {frac[14:0], 1'b0};
            if (y >= (64'd1 << 31)) begin
                frac[0] = 1'b1;
                y = y >> 1;
            end
        end
        d = (64'd23 << 16) - ((64'(msb) << 16) | 64'(frac));
        return -int'((d * 64'd394566 + (64'd1 << 23)) >> 24);
    endfunction

    function automatic logic [15:0] gain_q8(input int sg);
        longint g;
        g = (longint'(sg) + 128) >>> 8;
        if (g > 32767) begin
            g = 32767;
        end
        return g[15:0];
    endfunction

    function automatic fac_result_t compress(input logic signed [23:0] x,
                                             input logic signed [23:0] sc);
        fac_result_t res;
        logic [63:0] xm, sm, mag, mant, wet, acc, b, o, lim, w, ir;
        logic        xneg;
        int          main_lv, sc_lv, det, d, gc, shift;
        longint      g16, sum, a, l2, n;
        xneg = x[23];
        xm = xneg ? (64'd1 << 24) - 64'({1'b0, x}) : 64'({1'b0, x});
        xm = xm & 64'hFF_FFFF | (xneg && x == 24'sh800000 ? 64'h80_0000 : 0);
        if (!shadow_cfg.enabled) begin
            res.sample = x;
            res.gain   = gain_q8(held_gain_q16);
            return res;
        end
        sm = sc[23] ? (64'd1 << 24) - 64'({1'b0, sc}) : 64'({1'b0, sc});
        main_lv = level_dbfs(xm);
        if (main_lv < int'(MAIN_FLOOR)) begin
            main_lv = int'(MAIN_FLOOR);
        end
        main_lv += int'(DBU_OFFSET);
        sc_lv = level_dbfs(sm) + int'(DBU_OFFSET);
        det = shadow_cfg.use_sidechain ? sc_lv : main_lv;
        gc = 0;
        if (det > int'(shadow_cfg.threshold_level)) begin
            ir = shadow_cfg.inverse_ratio > 17'd65536 ? 64'd65536 : 64'(shadow_cfg.inverse_ratio);
            d = main_lv - int'(shadow_cfg.threshold_level);
            mag = 64'(d < 0 ? -d : d);
            mag = (mag * (64'd65536 - ir) + 64'd32768) >> 16;
            gc = d > 0 ? -int'(mag) : int'(mag);
            if (gc < -32768) gc = -32768;
            if (gc > 32767) gc = 32767;
        end
        // attack when the gain is falling, release otherwise
        g16 = longint'(gc) * 256;
        a = (g16 < longint'(held_gain_q16)) ? longint'(shadow_cfg.attack_coefficient)
                                            : longint'(shadow_cfg.release_coefficient);
        sum = g16 * (65536 - a) + longint'(held_gain_q16) * a;
        held_gain_q16 = int'((sum + 32768) >>> 16);
        l2 = (longint'(held_gain_q16) * 174165 + (longint'(1) << 19)) >>> 20;
        n = l2 >>> 16;
        shift = 30 - int'(n);
        mant = 64'd1 << 30;
        for (int i = 0; i < 16; i++) begin
            if (l2[15 - i]) begin
                mant = (mant * root_q30[i] + (64'd1 << 29)) >> 30;
            end
        end
        wet = xm * mant;
        wet = (wet + (64'd1 << (shift - 1))) >> shift;
        if (wet > WET_MAX) begin
            wet = WET_MAX;
        end
        w = shadow_cfg.wet_mix > 17'd65536 ? 64'd65536 : 64'(shadow_cfg.wet_mix);
        acc = xm * (64'd65536 - w) + wet * w;
        b = (acc + 64'd32768) >> 16;
        o = (b * 64'(shadow_cfg.makeup_gain) + 64'd2048) >> 12;
        lim = xneg ? 64'h80_0000 : 64'h7F_FFFF;
        if (o > lim) begin
            o = lim;
        end
        res.sample = xneg ? 24'(-o) : 24'(o);
        res.gain   = gain_q8(held_gain_q16);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        fac_result_t got;
        fac_result_t exp_res;
        if (!rst_n) begin
            shadow_cfg = '{enabled: 1'b0, threshold_level: '0, inverse_ratio: 17'd65536,
                           attack_coefficient: '0, release_coefficient: '0, wet_mix: '0,
                           makeup_gain: 16'd4096, use_sidechain: 1'b0};
            held_gain_q16 = 0;
            result_q.delete();
            errors = 0;
            pending = 0;
            requests = 0;
            compressed = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                got.sample = output_sample;
                got.gain   = gain_change;
                if (result_q.size() == 0) begin
                    $error("result with nothing expected: output_sample %0d", got.sample);
                    errors++;
                end
                else begin
                    exp_res = result_q.pop_front();
                    if (got.sample !== exp_res.sample) begin
                        $error("output_sample expected %0d actual %0d",
                               exp_res.sample, got.sample);
                        errors++;
                    end
                    if (got.gain !== exp_res.gain) begin
                        $error("gain_change expected %0d actual %0d",
                               exp_res.gain, got.gain);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                if (shadow_cfg.enabled) begin
                    compressed++;
                end
                result_q.push_back(compress(main_sample, sidechain_sample));
                requests++;
            end
            if (cfg_write) begin
                case (cfg_reg_t'(cfg_index))
                    REG_ENABLED:       shadow_cfg.enabled = cfg_data[0];
                    REG_THRESHOLD:     shadow_cfg.threshold_level = cfg_data[15:0];
                    REG_INV_RATIO:     shadow_cfg.inverse_ratio = cfg_data;
                    REG_ATTACK:        shadow_cfg.attack_coefficient = cfg_data[15:0];
                    REG_RELEASE:       shadow_cfg.release_coefficient = cfg_data[15:0];
                    REG_WET_MIX:       shadow_cfg.wet_mix = cfg_data;
                    REG_MAKEUP:        shadow_cfg.makeup_gain = cfg_data[15:0];
                    REG_USE_SIDECHAIN: shadow_cfg.use_sidechain = cfg_data[0];
                    default: ;
                endcase
            end
            pending = result_q.size();
        end
    end

    final begin
        if (result_q.size() != 0) begin
            $error("%0d results never arrived", result_q.size());
        end
    end

endmodule

### sim/tb_feedforward_audio_compressor_top.sv
module tb_feedforward_audio_compressor_top;
    import fac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [23:0]     main_sample;
    logic signed [23:0]     sidechain_sample;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [23:0]     output_sample;
    logic signed [15:0]     gain_change;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int errors;
    int pending;
    int requests;
    int compressed;
    int idle_cycles;
    int settings_used;
    bit hold_off;
    bit rx_quiet;
    bit tx_quiet;

    feedforward_audio_compressor_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .main_sample      (main_sample),
        .sidechain_sample (sidechain_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .output_sample    (output_sample),
        .gain_change      (gain_change),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    fac_scoreboard i_scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .main_sample      (main_sample),
        .sidechain_sample (sidechain_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .output_sample    (output_sample),
        .gain_change      (gain_change),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .errors           (errors),
        .pending          (pending),
        .requests         (requests),
        .compressed       (compressed)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver back-pressure
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (rx_quiet) begin
                out_stall <= 1'b0;
            end
            else begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    out_stall <= 1'b0;
                end
                else if (r < 96) begin
                    out_stall <= 1'b1;
                end
                else begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(20, 120)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait until the block is empty before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic send_request(input logic signed [23:0] m, input logic signed [23:0] s);
        int gap;
        in_valid         <= 1'b1;
        main_sample      <= m;
        sidechain_sample <= s;
        do begin
            @(posedge clk);
        end while (in_stall);
        if (tx_quiet) begin
            gap = 0;
        end
        else begin
            gap = $urandom_range(0, 99);
            gap = gap < 60 ? 0 : gap < 90 ? $urandom_range(1, 3) :
                  gap < 97 ? $urandom_range(4, 10) : $urandom_range(20, 80);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [23:0] pick_sample();
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return 24'sh000000;
            3: return $urandom_range(0, 1) ? 24'sh000001 : 24'shFFFFFF;
            4: return 24'($urandom());
            default: begin
                v = 24'($urandom_range(0, 24'h7FFFFF) >> $urandom_range(0, 22));
                return $urandom_range(0, 1) ? -24'(v) : 24'(v);
            end
        endcase
    endfunction

    task automatic apply_setting(input logic en, input int thr, input int ir, input int att,
                                 input int rel, input int wet, input int mk, input logic sc);
        drain();
        write_reg(REG_ENABLED, 17'(en));
        write_reg(REG_THRESHOLD, 17'(thr & 16'hFFFF));
        write_reg(REG_INV_RATIO, 17'(ir));
        write_reg(REG_ATTACK, 17'(att));
        write_reg(REG_RELEASE, 17'(rel));
        write_reg(REG_WET_MIX, 17'(wet));
        write_reg(REG_MAKEUP, 17'(mk));
        write_reg(REG_USE_SIDECHAIN, 17'(sc));
        settings_used++;
    endtask

    initial begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        main_sample      = '0;
        sidechain_sample = '0;
        cfg_write        = 1'b0;
        cfg_index        = REG_ENABLED;
        cfg_data         = '0;
        hold_off         = 1'b0;
        rx_quiet         = 1'b0;
        tx_quiet         = 1'b0;
        settings_used    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: pass-through
        send_request(24'sh7FFFFF, 24'sh800000);
        send_request(24'sh800000, 24'sh7FFFFF);
        send_request(24'sh000000, 24'sh000000);

        // hard compression, instant attack, full wet
        apply_setting(1, -20 * 256, 16384, 0, 0, 65536, 4096, 0);
        send_request(24'sh7FFFFF, 24'sh0);
        send_request(24'sh800000, 24'sh0);
        send_request(24'sh000000, 24'sh0);
        send_request(24'sh000001, 24'sh0);
        send_request(24'shFFFFFF, 24'sh0);
        send_request(24'sh001000, 24'sh0);
        // sidechain loud while main is quiet: gain goes up
        apply_setting(1, -10 * 256, 0, 0, 0, 65536, 65535, 1);
        send_request(24'sh000100, 24'sh7FFFFF);
        send_request(24'sh800000, 24'sh800000);
        send_request(24'sh000001, 24'sh7FFFFF);
        send_request(24'sh7FFFFF, 24'sh000000);
        // ratio and wet mix beyond unity saturate
        apply_setting(1, -32768, 17'h1FFFF, 65535, 65535, 17'h1FFFF, 0, 0);
        send_request(24'sh7FFFFF, 24'sh7FFFFF);
        send_request(24'sh400000, 24'sh000000);
        apply_setting(1, 32767, 0, 65535, 0, 32768, 65535, 1);
        send_request(24'sh7FFFFF, 24'sh7FFFFF);
        send_request(24'sh800000, 24'sh000000);
        send_request(24'sh123456, 24'shEDCBA9);
        // disabled holds the smoothed gain
        apply_setting(1, -30 * 256, 0, 0, 0, 65536, 4096, 1);
        send_request(24'sh000010, 24'sh7FFFFF);
        drain();
        write_reg(REG_ENABLED, 17'd0);
        send_request(24'sh7FFFFF, 24'sh7FFFFF);
        send_request(24'sh800000, 24'sh800000);

        for (int phase = 0; phase < 14; phase++) begin
            int thr;
            int ir;
            int wet;
            int mk;
            thr = $urandom_range(0, 4) == 0 ? int'($urandom_range(0, 65535)) - 32768
                                            : int'($urandom_range(0, 50 * 256)) - 30 * 256;
            ir  = $urandom_range(0, 5) == 0 ? $urandom_range(65537, 131071)
                                            : $urandom_range(0, 65536);
            wet = $urandom_range(0, 5) == 0 ? $urandom_range(0, 131071)
                                            : $urandom_range(0, 65536);
            mk  = $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
                                            : $urandom_range(2048, 12288);
            apply_setting($urandom_range(0, 7) != 0, thr, ir, $urandom_range(0, 65535),
                          $urandom_range(0, 65535), wet, mk, $urandom_range(0, 1));
            rx_quiet = (phase % 5) == 2;
            tx_quiet = (phase % 4) == 1;
            for (int k = 0; k < 108; k++) begin
                if (phase == 3 && k == 20) begin
                    hold_off = 1'b1;
                end
                if (phase == 6 && k == 50) begin
                    drain();
                end
                send_request(pick_sample(), pick_sample());
            end
            rx_quiet = 1'b0;
            tx_quiet = 1'b0;
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Ran %0d requests (%0d compressed) over %0d register settings.",
                 requests, compressed, settings_used);
        $display("Covered level extremes, sidechain detection, saturation and back-pressure.");
        if (errors == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
